>>> sv/kmdr_pkg.sv
`timescale 1ns / 1ps

package kmdr_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_FN_FIRST  = 2'd1;
   localparam logic [1:0] CSR_FN_SECOND = 2'd2;

   // configuration reset values
   localparam logic [7:0] THRESHOLD_RESET = 8'd20;
   localparam logic [6:0] FN_FIRST_RESET  = 7'd7;
   localparam logic [6:0] FN_SECOND_RESET = 7'd10;

   // item opcodes
   localparam logic OP_MAP_WRITE = 1'b0;
   localparam logic OP_SCAN      = 1'b1;

   // usage codes
   localparam logic [7:0] MOD_FIRST  = 8'hE0;
   localparam logic [7:0] MOD_LAST   = 8'hE7;
   localparam logic [7:0] SPACE_CODE = 8'h2C;

   // report slots carried on the result channel
   localparam int MAX_SLOTS = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_REPORT
   } kmdr_state_type;

   // one debounced key presented to the report builder
   typedef struct packed {
      logic       clear;
      logic       step;
      logic       down;
      logic       fn_layer;
      logic [7:0] fn_code;
      logic [7:0] nm_code;
   } kmdr_step_type;

   typedef struct packed {
      logic [7:0]                modifiers;
      logic [MAX_SLOTS-1:0][7:0] slots;
      logic [2:0]                used;
   } kmdr_report_type;

endpackage

>>> sv/kmdr_req_if.sv
`timescale 1ns / 1ps

interface kmdr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] matrix_bits;
   logic [6:0]  map_key;
   logic        map_layer;
   logic [7:0]  map_code;

   modport source (
      output valid, op, matrix_bits, map_key, map_layer, map_code,
      input  ready
   );

   modport sink (
      input  valid, op, matrix_bits, map_key, map_layer, map_code,
      output ready
   );
endinterface

>>> sv/kmdr_rsp_if.sv
`timescale 1ns / 1ps

interface kmdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_bits;
   logic [7:0] slot_zero;
   logic [7:0] slot_one;
   logic [7:0] slot_two;
   logic [7:0] slot_three;
   logic [7:0] slot_four;
   logic [7:0] slot_five;
   logic [2:0] slots_used;
   logic       fn_active;

   modport source (
      output valid, modifier_bits, slot_zero, slot_one, slot_two, slot_three,
             slot_four, slot_five, slots_used, fn_active,
      input  ready
   );

   modport sink (
      input  valid, modifier_bits, slot_zero, slot_one, slot_two, slot_three,
             slot_four, slot_five, slots_used, fn_active,
      output ready
   );
endinterface

>>> sv/kmdr_report_builder.sv
`timescale 1ns / 1ps

module kmdr_report_builder #(
   parameter int REPORT_SLOTS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kmdr_pkg::kmdr_step_type   step,
   output kmdr_pkg::kmdr_report_type report
);

   logic [7:0]                          mods_ff, mods_in;
   logic [kmdr_pkg::MAX_SLOTS-1:0][7:0] slots_ff, slots_in;
   logic [2:0]                          used_ff, used_in;
   logic                                space_ff, space_in;
   logic                                stop_ff, stop_in;
   logic [7:0]                          code;

   always_comb begin
      mods_in  = mods_ff;
      slots_in = slots_ff;
      used_in  = used_ff;
      space_in = space_ff;
      stop_in  = stop_ff;

      // function layer falls back to the normal layer on an empty code
      code = (step.fn_layer && step.fn_code != 8'd0) ? step.fn_code : step.nm_code;
      if (code == kmdr_pkg::SPACE_CODE && space_ff) begin
         code = 8'd0;
      end

      if (step.clear) begin
         mods_in  = '0;
         slots_in = '0;
         used_in  = '0;
         space_in = 1'b0;
         stop_in  = 1'b0;
      end else if (step.step && step.down && !stop_ff && code != 8'd0) begin
         if (code >= kmdr_pkg::MOD_FIRST && code <= kmdr_pkg::MOD_LAST) begin
            mods_in[code[2:0]] = 1'b1;
         end else begin
            if (used_ff < 3'(kmdr_pkg::MAX_SLOTS)) begin
               slots_in[used_ff] = code;
            end
            if (code == kmdr_pkg::SPACE_CODE) begin
               space_in = 1'b1;
            end
            used_in = used_ff + 3'd1;
            stop_in = (used_in >= 3'(REPORT_SLOTS));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         space_ff <= 1'b0;
         stop_ff  <= 1'b0;
      end else begin
         used_ff  <= used_in;
         space_ff <= space_in;
         stop_ff  <= stop_in;
      end
      mods_ff  <= mods_in;
      slots_ff <= slots_in;
   end

   assign report.modifiers = mods_ff;
   assign report.slots     = slots_ff;
   assign report.used      = used_ff;

endmodule

>>> sv/keyboard_matrix_debounce_report_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake          carries
// req_chan  in   valid/ready        op, matrix_bits, map_key, map_layer, map_code
// rsp_chan  out  valid/ready        modifier_bits, slot_zero..slot_five, slots_used,
//                                   fn_active
// csr_*     in   write enable only  csr_index, csr_write_data
//
// a keymap write is stored when it is taken; a scan walks through the counter and
// keymap memories, one key a cycle
// reset is synchronous; counters read as zero after reset through per-key valid
// flops, so no clearing pass is needed; the keymap is undefined until written
// a finished report waits in the output register, so a new item is taken while
// rsp_chan stalls; a scan done before that report leaves waits in its last state

module keyboard_matrix_debounce_report_core #(
   parameter int NUM_KEYS      = 64,
   parameter int REPORT_SLOTS  = 6,
   parameter int COUNTER_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   kmdr_req_if.sink   req_chan,
   kmdr_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   localparam int IW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int KM_DEPTH = 2 * (1 << IW);
   localparam int TW       = (COUNTER_WIDTH > 8) ? COUNTER_WIDTH : 8;

   // configuration registers
   logic [7:0] threshold_ff;
   logic [6:0] fn_first_ff;
   logic [6:0] fn_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kmdr_pkg::THRESHOLD_RESET;
         fn_first_ff  <= kmdr_pkg::FN_FIRST_RESET;
         fn_second_ff <= kmdr_pkg::FN_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            kmdr_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data;
            kmdr_pkg::CSR_FN_FIRST:  fn_first_ff  <= csr_write_data[6:0];
            kmdr_pkg::CSR_FN_SECOND: fn_second_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // threshold clamped to one at the bottom and the counter maximum at the top
   logic [TW-1:0]            thr_ext;
   logic [TW-1:0]            thr_clamped;
   logic [COUNTER_WIDTH-1:0] thr;

   always_comb begin
      thr_ext = TW'(threshold_ff);
      if (thr_ext == '0) begin
         thr_clamped = TW'(1);
      end else if (thr_ext > TW'((1 << COUNTER_WIDTH) - 1)) begin
         thr_clamped = TW'((1 << COUNTER_WIDTH) - 1);
      end else begin
         thr_clamped = thr_ext;
      end
      thr = thr_clamped[COUNTER_WIDTH-1:0];
   end

   // control
   kmdr_pkg::kmdr_state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          req_fire;
   logic          scan_fire;
   logic          map_fire;
   logic          walk_issue;
   logic          load_out;
   logic          out_free;
   logic          rsp_valid_ff;
   logic          last_idx;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign scan_fire = req_fire && (req_chan.op == kmdr_pkg::OP_SCAN);
   assign map_fire  = req_fire && (req_chan.op == kmdr_pkg::OP_MAP_WRITE);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_idx  = (idx_ff == IW'(NUM_KEYS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmdr_pkg::ST_IDLE:   if (scan_fire) state_in = kmdr_pkg::ST_WALK;
         kmdr_pkg::ST_WALK:   if (last_idx) state_in = kmdr_pkg::ST_FLUSH;
         kmdr_pkg::ST_FLUSH:  state_in = kmdr_pkg::ST_REPORT;
         kmdr_pkg::ST_REPORT: if (out_free) state_in = kmdr_pkg::ST_IDLE;
         default:             state_in = kmdr_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      walk_issue     = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         kmdr_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         kmdr_pkg::ST_WALK:   walk_issue     = 1'b1;
         kmdr_pkg::ST_FLUSH:  ;
         kmdr_pkg::ST_REPORT: load_out       = out_free;
         default:             ;
      endcase
   end

   // key address of the read being issued
   always_comb begin
      idx_in = idx_ff;
      if (scan_fire) begin
         idx_in = '0;
      end else if (walk_issue && !last_idx) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmdr_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // function layer select from the raw matrix of the accepted scan
   logic [6:0] fn_first_m1;
   logic [6:0] fn_second_m1;
   logic       fn_hit;
   logic       fn_ff;
   logic [NUM_KEYS-1:0] matrix_ff;

   always_comb begin
      fn_first_m1  = fn_first_ff - 7'd1;
      fn_second_m1 = fn_second_ff - 7'd1;
      fn_hit = (fn_first_ff != 7'd0 && fn_first_ff <= 7'(NUM_KEYS)
                && req_chan.matrix_bits[fn_first_m1[5:0]])
            || (fn_second_ff != 7'd0 && fn_second_ff <= 7'(NUM_KEYS)
                && req_chan.matrix_bits[fn_second_m1[5:0]]);
   end

   always_ff @(posedge clock) begin
      if (scan_fire) begin
         fn_ff     <= fn_hit;
         matrix_ff <= req_chan.matrix_bits[NUM_KEYS-1:0];
      end
   end

   // counter memory, one entry per key, with valid flops standing in for reset
   logic [COUNTER_WIDTH-1:0] cnt_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]      cnt_valid_ff;
   logic [COUNTER_WIDTH-1:0] cnt_rd_ff;
   logic                     cnt_rd_valid_ff;

   // keymap memory, normal layer in the lower half, function layer in the upper
   logic [7:0] km_mem [KM_DEPTH];
   logic [7:0] km_nm_rd_ff;
   logic [7:0] km_fn_rd_ff;
   logic [6:0] map_key_m1;
   logic       map_key_ok;

   // second stage: data for the key whose read was issued in the previous cycle
   logic                     p_valid_ff;
   logic [IW-1:0]            p_idx_ff;
   logic [COUNTER_WIDTH-1:0] cnt_old;
   logic [COUNTER_WIDTH-1:0] cnt_new;
   logic                     key_down;

   assign map_key_m1 = req_chan.map_key - 7'd1;
   assign map_key_ok = (req_chan.map_key != 7'd0) && (req_chan.map_key <= 7'(NUM_KEYS));

   always_comb begin
      cnt_old = cnt_rd_valid_ff ? cnt_rd_ff : '0;
      if (matrix_ff[p_idx_ff]) begin
         cnt_new = (cnt_old < thr) ? cnt_old + COUNTER_WIDTH'(1) : cnt_old;
      end else begin
         cnt_new = '0;
      end
      key_down = (cnt_new >= thr);
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff       <= cnt_mem[idx_ff];
      cnt_rd_valid_ff <= cnt_valid_ff[idx_ff];
      km_nm_rd_ff     <= km_mem[{1'b0, idx_ff}];
      km_fn_rd_ff     <= km_mem[{1'b1, idx_ff}];
      p_idx_ff        <= idx_ff;
      if (p_valid_ff) begin
         cnt_mem[p_idx_ff] <= cnt_new;
      end
      if (map_fire && map_key_ok) begin
         km_mem[{req_chan.map_layer, map_key_m1[IW-1:0]}] <= req_chan.map_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
         p_valid_ff   <= 1'b0;
      end else begin
         p_valid_ff <= walk_issue;
         if (p_valid_ff) begin
            cnt_valid_ff[p_idx_ff] <= 1'b1;
         end
      end
   end

   // report accumulation
   kmdr_pkg::kmdr_step_type   step;
   kmdr_pkg::kmdr_report_type report;

   always_comb begin
      step.clear    = scan_fire;
      step.step     = p_valid_ff;
      step.down     = key_down;
      step.fn_layer = fn_ff;
      step.fn_code  = km_fn_rd_ff;
      step.nm_code  = km_nm_rd_ff;
   end

   kmdr_report_builder #(
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_report (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .report (report)
   );

   // output register
   kmdr_pkg::kmdr_report_type out_ff;
   logic                      out_fn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         out_ff    <= report;
         out_fn_ff <= fn_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.modifier_bits = out_ff.modifiers;
   assign rsp_chan.slot_zero     = out_ff.slots[0];
   assign rsp_chan.slot_one      = out_ff.slots[1];
   assign rsp_chan.slot_two      = out_ff.slots[2];
   assign rsp_chan.slot_three    = out_ff.slots[3];
   assign rsp_chan.slot_four     = out_ff.slots[4];
   assign rsp_chan.slot_five     = out_ff.slots[5];
   assign rsp_chan.slots_used    = out_ff.used;
   assign rsp_chan.fn_active     = out_fn_ff;

endmodule

>>> test/keyboard_matrix_debounce_report_core_tb.sv
`timescale 1ns / 1ps

module keyboard_matrix_debounce_report_core_tb;

   localparam int NUM_KEYS     = 64;
   localparam int REPORT_SLOTS = 6;
   // long enough to cover a scan walk still in progress
   localparam int DRAIN_CYCLES = NUM_KEYS + 16;
   localparam int STALL_LIMIT  = 5000;

   typedef struct {
      logic        op;
      logic [63:0] matrix_bits;
      logic [6:0]  map_key;
      logic        map_layer;
      logic [7:0]  map_code;
   } kbd_item_type;

   typedef struct {
      logic [7:0] modifiers;
      logic [7:0] slots [kmdr_pkg::MAX_SLOTS];
      logic [2:0] used;
      logic       fn_active;
   } key_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   kmdr_req_if req_chan ();
   kmdr_rsp_if rsp_chan ();

   keyboard_matrix_debounce_report_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block: debounce counters, keymap and registers
   logic [7:0] press_count [NUM_KEYS];
   logic [7:0] key_codes [2*NUM_KEYS];
   logic [7:0] threshold_reg;
   logic [6:0] fn_first_reg;
   logic [6:0] fn_second_reg;

   kbd_item_type   queued_items [$];
   key_report_type awaited_reports [$];
   kbd_item_type   driven_item;
   logic           item_in_flight = 1'b0;
   logic [63:0]    held_keys;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             mismatch_count = 0;
   int             stall_cycles = 0;

   // debounce one scan and build the report it yields
   function automatic key_report_type scan_to_report(logic [63:0] bits);
      key_report_type rep;
      logic [7:0]     thr;
      logic [7:0]     code;
      logic           fn_hit;
      logic           space_taken;
      int             used;
      rep.modifiers = '0;
      foreach (rep.slots[n]) rep.slots[n] = '0;
      fn_hit = 1'b0;
      space_taken = 1'b0;
      used = 0;
      // a zero threshold acts as one
      thr = (threshold_reg == 8'd0) ? 8'd1 : threshold_reg;

      for (int k = 1; k <= NUM_KEYS; k++) begin
         if (bits[k-1]) begin
            if (press_count[k-1] < thr) press_count[k-1]++;
            if (k == fn_first_reg || k == fn_second_reg) fn_hit = 1'b1;
         end else begin
            press_count[k-1] = '0;
         end
      end

      for (int k = 1; k <= NUM_KEYS; k++) begin
         if (press_count[k-1] < thr) continue;
         code = fn_hit ? key_codes[NUM_KEYS + k - 1] : key_codes[k-1];
         // empty function layer entry falls back to the normal layer
         if (fn_hit && code == 8'd0) code = key_codes[k-1];
         // only the first space is reported
         if (code == kmdr_pkg::SPACE_CODE && space_taken) code = 8'd0;
         if (code == 8'd0) continue;
         if (code >= kmdr_pkg::MOD_FIRST && code <= kmdr_pkg::MOD_LAST) begin
            rep.modifiers[code[2:0]] = 1'b1;
         end else begin
            if (used < kmdr_pkg::MAX_SLOTS) rep.slots[used] = code;
            if (code == kmdr_pkg::SPACE_CODE) space_taken = 1'b1;
            used++;
         end
         // full report ends the walk, later modifiers are dropped too
         if (used >= REPORT_SLOTS) break;
      end

      rep.used = 3'(used);
      rep.fn_active = fn_hit;
      return rep;
   endfunction

   task automatic apply_item(kbd_item_type item);
      if (item.op == kmdr_pkg::OP_MAP_WRITE) begin
         // out-of-range key indexes are dropped
         if (item.map_key >= 7'd1 && item.map_key <= 7'(NUM_KEYS))
            key_codes[{item.map_layer, 6'(item.map_key - 7'd1)}] = item.map_code;
      end else begin
         awaited_reports.push_back(scan_to_report(item.matrix_bits));
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_report();
      key_report_type want;
      logic [7:0]     got_slots [kmdr_pkg::MAX_SLOTS];
      if (awaited_reports.size() == 0) begin
         report_mismatch("report arrived with none awaited");
         return;
      end
      want = awaited_reports.pop_front();
      got_slots = '{rsp_chan.slot_zero, rsp_chan.slot_one, rsp_chan.slot_two,
                    rsp_chan.slot_three, rsp_chan.slot_four, rsp_chan.slot_five};
      if (rsp_chan.modifier_bits !== want.modifiers)
         report_mismatch($sformatf("modifier_bits got %02h want %02h",
                                   rsp_chan.modifier_bits, want.modifiers));
      for (int n = 0; n < kmdr_pkg::MAX_SLOTS; n++)
         if (got_slots[n] !== want.slots[n])
            report_mismatch($sformatf("slot %0d got %02h want %02h",
                                      n, got_slots[n], want.slots[n]));
      if (rsp_chan.slots_used !== want.used)
         report_mismatch($sformatf("slots_used got %0d want %0d",
                                   rsp_chan.slots_used, want.used));
      if (rsp_chan.fn_active !== want.fn_active)
         report_mismatch($sformatf("fn_active got %0b want %0b",
                                   rsp_chan.fn_active, want.fn_active));
   endtask

   // item driver: holds valid until taken, idles at random between items
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         item_in_flight = 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_item(driven_item);
            item_in_flight = 1'b0;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_item = queued_items.pop_front();
               item_in_flight = 1'b1;
               req_chan.valid       <= 1'b1;
               req_chan.op          <= driven_item.op;
               req_chan.matrix_bits <= driven_item.matrix_bits;
               req_chan.map_key     <= driven_item.map_key;
               req_chan.map_layer   <= driven_item.map_layer;
               req_chan.map_code    <= driven_item.map_code;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // report monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_report();
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [63:0] sparse_keys();
      return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] pick_usage_code();
      int r;
      r = $urandom_range(99);
      if (r < 20) return 8'h00;
      if (r < 40) return kmdr_pkg::MOD_FIRST + 8'($urandom_range(7));
      if (r < 52) return kmdr_pkg::SPACE_CODE;
      return 8'($urandom_range(255));
   endfunction

   task automatic push_map_write(logic [6:0] key, logic layer, logic [7:0] code);
      queued_items.push_back('{kmdr_pkg::OP_MAP_WRITE, {$urandom, $urandom}, key, layer,
                               code});
   endtask

   task automatic push_scan(logic [63:0] bits);
      queued_items.push_back('{kmdr_pkg::OP_SCAN, bits, 7'($urandom), 1'($urandom),
                               8'($urandom)});
   endtask

   // held keys persist across scans so counters climb; noise and churn break them up
   task automatic add_random_traffic(int count, int churn_pct);
      logic [63:0] bits;
      logic [6:0]  key;
      repeat (count) begin
         if ($urandom_range(99) < 8) begin
            if ($urandom_range(9) == 0)
               key = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
            else
               key = 7'($urandom_range(1, NUM_KEYS));
            push_map_write(key, 1'($urandom), pick_usage_code());
         end else begin
            if ($urandom_range(99) < churn_pct)
               repeat ($urandom_range(1, 4)) held_keys[$urandom_range(63)] ^= 1'b1;
            if ($urandom_range(999) < churn_pct * 3) held_keys = sparse_keys();
            bits = held_keys;
            if ($urandom_range(99) < 30) bits |= sparse_keys() & {$urandom, $urandom};
            if (fn_first_reg >= 7'd1 && fn_first_reg <= 7'(NUM_KEYS) && $urandom_range(99) < 25)
               bits[fn_first_reg - 7'd1] = 1'b1;
            if (fn_second_reg >= 7'd1 && fn_second_reg <= 7'(NUM_KEYS)
                && $urandom_range(99) < 15)
               bits[fn_second_reg - 7'd1] = 1'b1;
            push_scan(bits);
         end
      end
   endtask

   // the sender holds off until every report is back and the walk has ended
   task automatic wait_for_drain();
      do @(posedge clock);
      while (queued_items.size() != 0 || item_in_flight || awaited_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         kmdr_pkg::CSR_THRESHOLD: threshold_reg = data;
         kmdr_pkg::CSR_FN_FIRST:  fn_first_reg = data[6:0];
         kmdr_pkg::CSR_FN_SECOND: fn_second_reg = data[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] thr, logic [7:0] fn_left, logic [7:0] fn_right);
      csr_write(kmdr_pkg::CSR_THRESHOLD, thr);
      csr_write(kmdr_pkg::CSR_FN_FIRST, fn_left);
      csr_write(kmdr_pkg::CSR_FN_SECOND, fn_right);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.op          = kmdr_pkg::OP_SCAN;
      req_chan.matrix_bits = '0;
      req_chan.map_key     = '0;
      req_chan.map_layer   = 1'b0;
      req_chan.map_code    = '0;
      rsp_chan.ready       = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = kmdr_pkg::CSR_THRESHOLD;
      csr_write_data       = '0;
      foreach (press_count[i]) press_count[i] = '0;
      foreach (key_codes[i]) key_codes[i] = '0;
      threshold_reg = kmdr_pkg::THRESHOLD_RESET;
      fn_first_reg  = kmdr_pkg::FN_FIRST_RESET;
      fn_second_reg = kmdr_pkg::FN_SECOND_RESET;
      held_keys = sparse_keys();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset register values; whole keymap loaded before the first scan
      send_idle_pct = 38;
      recv_idle_pct = 86;
      for (int layer = 0; layer < 2; layer++)
         for (int k = 1; k <= NUM_KEYS; k++)
            push_map_write(7'(k), 1'(layer), pick_usage_code());
      add_random_traffic(110, 10);
      wait_for_drain();

      // threshold one: every pressed key is down at once
      set_config(8'd1, 8'd7, 8'd10);
      push_map_write(7'd1, 1'b0, kmdr_pkg::SPACE_CODE);
      push_map_write(7'd2, 1'b0, kmdr_pkg::SPACE_CODE);
      push_map_write(7'd3, 1'b0, kmdr_pkg::MOD_FIRST);
      push_map_write(7'd4, 1'b0, kmdr_pkg::MOD_LAST);
      push_map_write(7'd5, 1'b1, 8'h00);
      push_map_write(7'd5, 1'b0, 8'h04);
      push_map_write(7'd64, 1'b1, 8'h05);
      push_map_write(7'd64, 1'b0, 8'h06);
      // key indexes outside the matrix, ignored
      push_map_write(7'd0, 1'b0, 8'hFF);
      push_map_write(7'd65, 1'b1, 8'hFF);
      push_map_write(7'd127, 1'b1, 8'hFF);
      push_scan(64'h0);
      // two spaces and both ends of the modifier range
      push_scan(64'hF);
      // keys 5 and 6 with no function key held; key 5 has an empty function layer entry
      push_scan(64'h30);
      // last key under the right function key
      push_scan(64'h8000_0000_0000_0200);
      push_scan(64'h8000_0000_0000_0000);
      // everything pressed fills the report
      push_scan('1);
      push_scan(~64'h0000_0000_0000_0240);
      push_scan(64'h4F);
      add_random_traffic(70, 15);
      wait_for_drain();

      // top threshold: long holds with little churn
      send_idle_pct = 86;
      recv_idle_pct = 38;
      set_config(8'd255, 8'd64, 8'd1);
      held_keys = sparse_keys();
      add_random_traffic(260, 1);
      wait_for_drain();

      // zero threshold and function keys that match nothing
      set_config(8'd0, 8'd0, 8'd100);
      add_random_traffic(70, 10);
      wait_for_drain();

      // no idling from here on; upper data bit of a function key write is dropped
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'($urandom_range(2, 6)), 8'($urandom_range(1, NUM_KEYS)),
                 8'h80 | 8'($urandom_range(1, NUM_KEYS)));
      add_random_traffic(80, 20);
      wait_for_drain();

      set_config(8'd3, 8'($urandom_range(1, NUM_KEYS)), 8'($urandom_range(1, NUM_KEYS)));
      add_random_traffic(60, 10);
      wait_for_drain();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
